// File: rtl/emr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exact-match route table package
// Shared types and constants for the route table and its entry cells.
// ----------------------------------------------------------------------------
package emr_pkg;

    localparam int EMR_TABLE_ENTRIES   = 64;
    localparam int EMR_KEY_BITS        = 32;
    localparam int EMR_ROUTE_KEY_BITS  = 32;
    localparam int EMR_IFACE_BITS      = 32;
    // Cells between two registers of the match carry chain
    localparam int EMR_CELLS_PER_STAGE = 8;

    localparam logic [EMR_IFACE_BITS-1:0] EMR_IFACE_NONE = '1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } emr_op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } emr_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } emr_state_t;

    typedef struct packed {
        emr_op_t                     opcode;
        logic [EMR_ROUTE_KEY_BITS-1:0] route_key;
        logic [EMR_IFACE_BITS-1:0]   iface_in;
    } emr_req_t;

    typedef struct packed {
        emr_status_t               status;
        logic [EMR_IFACE_BITS-1:0] iface_out;
    } emr_rsp_t;

    // Update command broadcast to every cell
    typedef struct packed {
        logic shift_in;   // take the entry of the newer neighbor
        logic remove;     // take the older neighbor at and after the first match
        logic clear;      // drop every entry
    } emr_cmd_t;

    // Newest-match carry handed from cell to cell
    typedef struct packed {
        logic                      found;
        logic [EMR_IFACE_BITS-1:0] iface;
    } emr_carry_t;

endpackage : emr_pkg
`default_nettype wire

// File: rtl/exact_match_route_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exact-match route table
// Ordered key to interface table, newest entry first, built as a chain of
// entry cells. Supports lookup, add, delete and clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request transaction: opcode, route_key,
//   iface_in. m_valid/m_ready/m_data return one result transaction for every
//   request: status and iface_out. Only the low KEY_BITS bits of the key are
//   stored and compared.
//   One request is processed at a time. Add and clear go from acceptance
//   straight to the commit state, where the result is registered. Lookup and
//   delete first wait in the scan state while the newest-match carry passes
//   the S = ceil(TABLE_ENTRIES / 8) registered stages of the carry chain
//   through the cells (S = 8 for 64 entries). The next request is accepted
//   in the cycle after the result is registered.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the following result is held back until the receiver takes
//   the current one.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module exact_match_route_table
    import emr_pkg::*;
#(
    parameter int TABLE_ENTRIES = EMR_TABLE_ENTRIES,
    parameter int KEY_BITS      = EMR_KEY_BITS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire emr_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output emr_rsp_t      m_data
);

    localparam int KEY_W       = (KEY_BITS < EMR_ROUTE_KEY_BITS) ? KEY_BITS
                                                                 : EMR_ROUTE_KEY_BITS;
    localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int SCAN_STAGES = (TABLE_ENTRIES + EMR_CELLS_PER_STAGE - 1)
                                 / EMR_CELLS_PER_STAGE;
    localparam int SCAN_W      = $clog2(SCAN_STAGES + 1);

    emr_state_t                state_reg, state_next;
    logic [SCAN_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      m_valid_reg, m_valid_next;
    emr_rsp_t                  rsp_reg, rsp_next;
    emr_op_t                   op_reg;
    logic [KEY_W-1:0]          key_reg;
    logic [EMR_IFACE_BITS-1:0] iface_reg;
    emr_cmd_t                  cmd;
    logic                      commit_go;
    logic                      table_full;

    logic [KEY_W-1:0]          key_chain   [TABLE_ENTRIES];
    logic [EMR_IFACE_BITS-1:0] iface_chain [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  valid_vec;
    emr_carry_t                carry_chain [TABLE_ENTRIES];
    emr_carry_t                scan_result;

    // Latch the request on acceptance
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_data.opcode;
            key_reg   <= s_data.route_key[KEY_W-1:0];
            iface_reg <= s_data.iface_in;
        end
    end

    // Cell chain: slot 0 is the newest entry
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            logic [KEY_W-1:0]          prev_key,   next_key;
            logic [EMR_IFACE_BITS-1:0] prev_iface, next_iface;
            logic                      prev_valid, next_valid;
            emr_carry_t                carry_in;

            if (gi == 0) begin : g_head
                assign prev_key   = key_reg;
                assign prev_iface = iface_reg;
                assign prev_valid = 1'b1;
                assign carry_in   = '0;
            end else begin : g_body
                assign prev_key   = key_chain[gi-1];
                assign prev_iface = iface_chain[gi-1];
                assign prev_valid = valid_vec[gi-1];
                assign carry_in   = carry_chain[gi-1];
            end

            if (gi == TABLE_ENTRIES - 1) begin : g_tail
                assign next_key   = '0;
                assign next_iface = '0;
                assign next_valid = 1'b0;
            end else begin : g_inner
                assign next_key   = key_chain[gi+1];
                assign next_iface = iface_chain[gi+1];
                assign next_valid = valid_vec[gi+1];
            end

            emr_cell #(
                .KEY_W     (KEY_W),
                .CARRY_REG (((gi % EMR_CELLS_PER_STAGE) == EMR_CELLS_PER_STAGE - 1)
                            || (gi == TABLE_ENTRIES - 1))
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .req_key    (key_reg),
                .prev_key   (prev_key),
                .prev_iface (prev_iface),
                .prev_valid (prev_valid),
                .next_key   (next_key),
                .next_iface (next_iface),
                .next_valid (next_valid),
                .key_out    (key_chain[gi]),
                .iface_out  (iface_chain[gi]),
                .valid_out  (valid_vec[gi]),
                .carry_in   (carry_in),
                .carry_out  (carry_chain[gi])
            );
        end
    endgenerate

    assign scan_result = carry_chain[TABLE_ENTRIES-1];
    assign table_full  = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign commit_go   = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        rsp_next      = rsp_reg;
        cmd           = '0;
        s_ready       = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    scan_cnt_next = '0;
                    if (s_data.opcode == OP_LOOKUP || s_data.opcode == OP_DELETE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_SCAN: begin
                // Wait for the carry to settle through every registered stage
                if (scan_cnt_reg == SCAN_W'(SCAN_STAGES - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (commit_go) begin
                    state_next         = ST_IDLE;
                    m_valid_next       = 1'b1;
                    rsp_next.status    = STAT_OK;
                    rsp_next.iface_out = EMR_IFACE_NONE;
                    unique case (op_reg)
                        OP_LOOKUP: begin
                            if (scan_result.found) begin
                                rsp_next.iface_out = scan_result.iface;
                            end else begin
                                rsp_next.status = STAT_NOT_FOUND;
                            end
                        end
                        OP_ADD: begin
                            if (table_full) begin
                                rsp_next.status = STAT_FULL;
                            end else begin
                                cmd.shift_in = 1'b1;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (scan_result.found) begin
                                cmd.remove = 1'b1;
                                count_next = count_reg - 1'b1;
                            end else begin
                                rsp_next.status = STAT_NOT_FOUND;
                            end
                        end
                        OP_CLEAR: begin
                            cmd.clear  = 1'b1;
                            count_next = '0;
                        end
                        default: begin
                            rsp_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    // Occupancy never exceeds capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above capacity");

    // Live entries are exactly the counted ones
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(count_reg))
        else $error("valid cells disagree with entry count");

    // Searching operations go through the carry scan
    a_scan_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready
        && (s_data.opcode == OP_LOOKUP || s_data.opcode == OP_DELETE)
        |=> state_reg == ST_SCAN)
        else $error("lookup or delete skipped the scan");

    // Add on a full table reports full and leaves the count alone
    a_add_full: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_go && op_reg == OP_ADD && table_full
        |=> rsp_reg.status == STAT_FULL && count_reg == $past(count_reg))
        else $error("add on full table mishandled");

    // A successful delete drops exactly one entry
    a_delete_count: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_go && op_reg == OP_DELETE && scan_result.found
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not remove one entry");

endmodule : exact_match_route_table
`default_nettype wire

// File: rtl/emr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Route table entry cell
// Holds one key and interface pair, compares it with the request key and
// passes the newest-match carry and its entry to its neighbors.
// ----------------------------------------------------------------------------
module emr_cell
    import emr_pkg::*;
#(
    parameter int KEY_W     = EMR_KEY_BITS,
    parameter bit CARRY_REG = 1'b0
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire emr_cmd_t                  cmd,
    input  wire logic [KEY_W-1:0]          req_key,
    input  wire logic [KEY_W-1:0]          prev_key,
    input  wire logic [EMR_IFACE_BITS-1:0] prev_iface,
    input  wire logic                      prev_valid,
    input  wire logic [KEY_W-1:0]          next_key,
    input  wire logic [EMR_IFACE_BITS-1:0] next_iface,
    input  wire logic                      next_valid,
    output logic [KEY_W-1:0]               key_out,
    output logic [EMR_IFACE_BITS-1:0]      iface_out,
    output logic                           valid_out,
    input  wire emr_carry_t                carry_in,
    output emr_carry_t                     carry_out
);

    logic [KEY_W-1:0]          key_reg;
    logic [EMR_IFACE_BITS-1:0] iface_reg;
    logic                      valid_reg;
    logic                      match;
    emr_carry_t                carry_next;

    assign match = valid_reg && (key_reg == req_key);

    always_comb begin
        carry_next.found = carry_in.found | match;
        carry_next.iface = carry_in.found ? carry_in.iface : iface_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.clear) begin
            valid_reg <= 1'b0;
        end else if (cmd.shift_in) begin
            valid_reg <= prev_valid;
        end else if (cmd.remove && carry_next.found) begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_in) begin
            key_reg   <= prev_key;
            iface_reg <= prev_iface;
        end else if (cmd.remove && carry_next.found) begin
            key_reg   <= next_key;
            iface_reg <= next_iface;
        end
    end

    assign key_out   = key_reg;
    assign iface_out = iface_reg;
    assign valid_out = valid_reg;

    generate
        if (CARRY_REG) begin : g_carry_reg
            emr_carry_t carry_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    carry_reg.found <= 1'b0;
                end else begin
                    carry_reg.found <= carry_next.found;
                end
                carry_reg.iface <= carry_next.iface;
            end

            assign carry_out = carry_reg;
        end else begin : g_carry_comb
            assign carry_out = carry_next;
        end
    endgenerate

endmodule : emr_cell
`default_nettype wire

// File: bench/exact_match_route_table_tb.sv
// ----------------------------------------------------------------------------
// Exact-match route table testbench
// Drives lookup, add, delete and clear requests through the valid/ready
// request channel, predicts each result with a local newest-first table, and
// compares every result transaction field by field. A short directed table
// covers empty and duplicate-key cases; phased random traffic follows.
// ----------------------------------------------------------------------------
module exact_match_route_table_tb;
    import emr_pkg::*;

    localparam int RANDOM_ITEMS  = 700;
    localparam int KEY_POOL      = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int DIRECTED_ROWS = 23;
    localparam logic [EMR_ROUTE_KEY_BITS-1:0] KEY_MASK =
        {EMR_ROUTE_KEY_BITS{1'b1}} >> (EMR_ROUTE_KEY_BITS - EMR_KEY_BITS);

    typedef struct packed {
        emr_op_t                       op;
        logic [EMR_ROUTE_KEY_BITS-1:0] key;
        logic [EMR_IFACE_BITS-1:0]     iface;
        logic                          known;
        emr_status_t                   want_status;
        logic [EMR_IFACE_BITS-1:0]     want_iface;
    } stim_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    emr_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    emr_rsp_t m_data;

    // Newest entry sits at index 0
    logic [EMR_ROUTE_KEY_BITS-1:0] route_keys[$];
    logic [EMR_IFACE_BITS-1:0]     route_ifaces[$];
    emr_rsp_t                      expected_rsp[$];
    logic [EMR_ROUTE_KEY_BITS-1:0] key_pool[KEY_POOL];

    int mismatch_count;
    int random_sent;
    int cycle_count;
    bit steady;

    stim_row_t directed_rows[DIRECTED_ROWS] = '{
        '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, EMR_IFACE_NONE},
        '{OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, EMR_IFACE_NONE},
        '{OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, STAT_OK,        EMR_IFACE_NONE},
        '{OP_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1, STAT_OK,        EMR_IFACE_NONE},
        '{OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STAT_OK,        32'hFFFF_FFFF},
        '{OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STAT_OK,        32'h0000_0000},
        '{OP_ADD,    32'h0000_0000, 32'h1234_5678, 1'b1, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'h5555_5555, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, EMR_IFACE_NONE},
        '{OP_ADD,    32'hAAAA_AAAA, 32'h5555_5555, 1'b0, STAT_OK,        EMR_IFACE_NONE},
        '{OP_ADD,    32'h8000_0001, 32'h7FFF_FFFE, 1'b0, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'h8000_0001, 32'hFFFF_FFFF, 1'b0, STAT_OK,        EMR_IFACE_NONE},
        '{OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,        EMR_IFACE_NONE},
        '{OP_DELETE, 32'h5555_5555, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, EMR_IFACE_NONE},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, STAT_OK,        EMR_IFACE_NONE},
        '{OP_CLEAR,  32'h1357_9BDF, 32'hFFFF_FFFF, 1'b1, STAT_OK,        EMR_IFACE_NONE},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, EMR_IFACE_NONE},
        '{OP_ADD,    32'h0000_0001, 32'h0000_0001, 1'b0, STAT_OK,        EMR_IFACE_NONE}
    };

    exact_match_route_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int newest_match(logic [EMR_ROUTE_KEY_BITS-1:0] key);
        for (int i = 0; i < route_keys.size(); i++) begin
            if (route_keys[i] == key) return i;
        end
        return -1;
    endfunction

    // Apply one request to the local table and return the result it gives
    function automatic emr_rsp_t route_table_apply(emr_req_t req);
        emr_rsp_t                      rsp;
        logic [EMR_ROUTE_KEY_BITS-1:0] key;
        int                            hit;
        rsp.status    = STAT_OK;
        rsp.iface_out = EMR_IFACE_NONE;
        key           = req.route_key & KEY_MASK;
        case (req.opcode)
            OP_LOOKUP: begin
                hit = newest_match(key);
                if (hit >= 0) rsp.iface_out = route_ifaces[hit];
                else rsp.status = STAT_NOT_FOUND;
            end
            OP_ADD: begin
                if (route_keys.size() >= EMR_TABLE_ENTRIES) begin
                    rsp.status = STAT_FULL;
                end else begin
                    route_keys.push_front(key);
                    route_ifaces.push_front(req.iface_in);
                end
            end
            OP_DELETE: begin
                hit = newest_match(key);
                if (hit < 0) begin
                    rsp.status = STAT_NOT_FOUND;
                end else begin
                    route_keys.delete(hit);
                    route_ifaces.delete(hit);
                end
            end
            default: begin
                route_keys.delete();
                route_ifaces.delete();
            end
        endcase
        return rsp;
    endfunction

    function automatic logic [EMR_ROUTE_KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 50 && route_keys.size() != 0)
            return route_keys[$urandom_range(route_keys.size() - 1)];
        if (r < 80) return key_pool[$urandom_range(KEY_POOL - 1)];
        return $urandom();
    endfunction

    function automatic logic [EMR_IFACE_BITS-1:0] pick_iface();
        if ($urandom_range(19) == 0) return EMR_IFACE_NONE;
        return $urandom();
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Enter and leave at a falling edge; record the expectation on acceptance
    task automatic issue_request(input emr_req_t req, input logic known,
                                 input emr_rsp_t typed);
        emr_rsp_t predicted;
        while (!steady && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = route_table_apply(req);
        expected_rsp.push_back(known ? typed : predicted);
        @(negedge aclk);
    endtask

    task automatic send_random(input emr_op_t op, input logic [EMR_ROUTE_KEY_BITS-1:0] key,
                               input logic [EMR_IFACE_BITS-1:0] iface);
        emr_req_t req;
        req.opcode    = op;
        req.route_key = key;
        req.iface_in  = iface;
        // hold both sides busy through one long stretch
        steady = (random_sent >= 250 && random_sent < 400);
        issue_request(req, 1'b0, '0);
        random_sent++;
    endtask

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 9);
    end

    always @(posedge aclk) begin : check_results
        emr_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp.size() == 0) begin
                flag_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_rsp.pop_front();
                if (m_data.status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            m_data.status, want.status));
                if (m_data.iface_out !== want.iface_out)
                    flag_mismatch($sformatf("iface_out %h, expected %h",
                                            m_data.iface_out, want.iface_out));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        emr_req_t req;
        emr_rsp_t typed;
        int       phase;
        int       mode;
        int       n;
        int       r;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        mismatch_count = 0;
        random_sent    = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            req.opcode      = directed_rows[i].op;
            req.route_key   = directed_rows[i].key;
            req.iface_in    = directed_rows[i].iface;
            typed.status    = directed_rows[i].want_status;
            typed.iface_out = directed_rows[i].want_iface;
            issue_request(req, directed_rows[i].known, typed);
        end

        // Phased traffic: fill to capacity and past it, churn, drain, noise
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mode = (phase == 0) ? 0 : $urandom_range(3);
            case (mode)
                0: begin
                    n = EMR_TABLE_ENTRIES - route_keys.size();
                    n = n + n / 6 + $urandom_range(2, 5);
                    for (int i = 0; i < n && random_sent < RANDOM_ITEMS; i++) begin
                        if (phase != 0 && $urandom_range(7) == 0)
                            send_random(OP_LOOKUP, pick_key(), pick_iface());
                        else
                            send_random(OP_ADD, pick_key(), pick_iface());
                    end
                end
                1: begin
                    n = $urandom_range(20, 60);
                    for (int i = 0; i < n && random_sent < RANDOM_ITEMS; i++) begin
                        r = $urandom_range(99);
                        if (r < 40) send_random(OP_LOOKUP, pick_key(), pick_iface());
                        else if (r < 65) send_random(OP_ADD, pick_key(), pick_iface());
                        else if (r < 97) send_random(OP_DELETE, pick_key(), pick_iface());
                        else send_random(OP_CLEAR, pick_key(), pick_iface());
                    end
                end
                2: begin
                    n = route_keys.size() + $urandom_range(2, 6);
                    for (int i = 0; i < n && random_sent < RANDOM_ITEMS; i++) begin
                        if ($urandom_range(9) < 7)
                            send_random(OP_DELETE, pick_key(), pick_iface());
                        else
                            send_random(OP_LOOKUP, pick_key(), pick_iface());
                    end
                end
                default: begin
                    n = $urandom_range(3, 10);
                    for (int i = 0; i < n && random_sent < RANDOM_ITEMS; i++) begin
                        req = emr_req_t'({$urandom(), $urandom(), $urandom()});
                        send_random(req.opcode, req.route_key, req.iface_in);
                    end
                end
            endcase
            phase++;
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        while (expected_rsp.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
